### design/phase_current_clarke_park_unit_defines.svh
// assertion macros for the phase current clarke/park unit
// used by the top level; expects clk and rst_n in the including scope
`ifndef PHASE_CURRENT_CLARKE_PARK_UNIT_DEFINES_SVH
`define PHASE_CURRENT_CLARKE_PARK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define PCP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define PCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define PCP_ASSERT_SAME(lbl, ante, cons, msg)

`define PCP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### design/pcp_pkg.sv
// shared types, q15 constants and microcode rom for the clarke/park unit
// no dependencies
`timescale 1ns / 1ps

package pcp_pkg;

  localparam int CAL_SAMPLES_LOG2_DEF = 10;
  localparam int ADC_BITS_DEF = 12;

  localparam int TRIG_W = 16;
  localparam int I_ALPHA_W = 17;
  localparam int I_BETA_W = 17;
  localparam int I_DIRECT_W = 19;
  localparam int I_QUAD_W = 19;
  localparam int OUT_DATA_W = I_ALPHA_W + I_BETA_W + I_DIRECT_W + I_QUAD_W;

  localparam logic signed [TRIG_W-1:0] Q15_HALF = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] Q15_TWO_THIRDS = 16'sd21845;
  localparam logic signed [TRIG_W-1:0] Q15_INV_SQRT3 = 16'sd18918;

  localparam int Q15_SHIFT = 15;
  localparam int STEP_W = 4;

  typedef enum logic [2:0] {
    X_HALF,
    X_TWO_THIRDS,
    X_INV_SQRT3,
    X_SIN,
    X_COS
  } xsel_t;

  typedef enum logic [2:0] {
    Y_BPC,
    Y_BMC,
    Y_TMP,
    Y_BETA,
    Y_ALPHA
  } ysel_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_TMP,
    DST_ALPHA,
    DST_BETA,
    DST_D,
    DST_Q
  } dst_t;

  typedef enum logic [1:0] {
    WB_SET,
    WB_ADD,
    WB_SUB
  } wbop_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_WAIT_IN,
    J_WAIT_OUT,
    J_HOME
  } jmp_t;

  typedef struct packed {
    xsel_t xsel;
    ysel_t ysel;
    dst_t  dst;
    wbop_t op;
    jmp_t  jmp;
  } ucode_t;

  // step 0 waits for a transaction, steps 1..7 issue one product each,
  // step 8 drains the last writeback, step 9 hands the result over
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{xsel: X_HALF, ysel: Y_BPC, dst: DST_NONE, op: WB_SET, jmp: J_HOME};
    unique case (step)
      4'd0: w = '{xsel: X_HALF, ysel: Y_BPC, dst: DST_NONE, op: WB_SET, jmp: J_WAIT_IN};
      4'd1: w = '{xsel: X_HALF, ysel: Y_BPC, dst: DST_TMP, op: WB_SUB, jmp: J_NEXT};
      4'd2: w = '{xsel: X_INV_SQRT3, ysel: Y_BMC, dst: DST_BETA, op: WB_SET, jmp: J_NEXT};
      4'd3: w = '{xsel: X_TWO_THIRDS, ysel: Y_TMP, dst: DST_ALPHA, op: WB_SET, jmp: J_NEXT};
      4'd4: w = '{xsel: X_SIN, ysel: Y_BETA, dst: DST_D, op: WB_SET, jmp: J_NEXT};
      4'd5: w = '{xsel: X_COS, ysel: Y_ALPHA, dst: DST_D, op: WB_ADD, jmp: J_NEXT};
      4'd6: w = '{xsel: X_COS, ysel: Y_BETA, dst: DST_Q, op: WB_SET, jmp: J_NEXT};
      4'd7: w = '{xsel: X_SIN, ysel: Y_ALPHA, dst: DST_Q, op: WB_SUB, jmp: J_NEXT};
      4'd8: w = '{xsel: X_HALF, ysel: Y_BPC, dst: DST_NONE, op: WB_SET, jmp: J_NEXT};
      4'd9: w = '{xsel: X_HALF, ysel: Y_BPC, dst: DST_NONE, op: WB_SET, jmp: J_WAIT_OUT};
      default: w = '{xsel: X_HALF, ysel: Y_BPC, dst: DST_NONE, op: WB_SET, jmp: J_HOME};
    endcase
    return w;
  endfunction

endpackage

### design/pcp_calib.sv
// offset calibration: accumulates raw phase samples and latches their mean
// standalone, no package dependency
`timescale 1ns / 1ps

module pcp_calib #(
  parameter int ADC_BITS = 12,
  parameter int CAL_SAMPLES_LOG2 = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cal_en,
  input  logic [ADC_BITS-1:0] sample_a,
  input  logic [ADC_BITS-1:0] sample_b,
  input  logic [ADC_BITS-1:0] sample_c,
  output logic [ADC_BITS-1:0] offset_a,
  output logic [ADC_BITS-1:0] offset_b,
  output logic [ADC_BITS-1:0] offset_c
);

  localparam int SUM_W = ADC_BITS + CAL_SAMPLES_LOG2;

  logic [SUM_W-1:0]            sum_a_r, sum_b_r, sum_c_r;
  logic [SUM_W-1:0]            sum_a_nxt, sum_b_nxt, sum_c_nxt;
  logic [SUM_W-1:0]            add_a, add_b, add_c;
  logic [CAL_SAMPLES_LOG2-1:0] count_r, count_nxt;
  logic [ADC_BITS-1:0]         off_a_r, off_b_r, off_c_r;
  logic [ADC_BITS-1:0]         off_a_nxt, off_b_nxt, off_c_nxt;

  always_comb begin
    add_a = sum_a_r + SUM_W'(sample_a);
    add_b = sum_b_r + SUM_W'(sample_b);
    add_c = sum_c_r + SUM_W'(sample_c);
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    sum_c_nxt = sum_c_r;
    count_nxt = count_r;
    off_a_nxt = off_a_r;
    off_b_nxt = off_b_r;
    off_c_nxt = off_c_r;
    if (cal_en) begin
      if (count_r == '1) begin
        off_a_nxt = add_a[SUM_W-1:CAL_SAMPLES_LOG2];
        off_b_nxt = add_b[SUM_W-1:CAL_SAMPLES_LOG2];
        off_c_nxt = add_c[SUM_W-1:CAL_SAMPLES_LOG2];
        sum_a_nxt = '0;
        sum_b_nxt = '0;
        sum_c_nxt = '0;
        count_nxt = '0;
      end else begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        sum_c_nxt = add_c;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_a_r <= '0;
      sum_b_r <= '0;
      sum_c_r <= '0;
      count_r <= '0;
      off_a_r <= '0;
      off_b_r <= '0;
      off_c_r <= '0;
    end else begin
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      sum_c_r <= sum_c_nxt;
      count_r <= count_nxt;
      off_a_r <= off_a_nxt;
      off_b_r <= off_b_nxt;
      off_c_r <= off_c_nxt;
    end
  end

  assign offset_a = off_a_r;
  assign offset_b = off_b_r;
  assign offset_c = off_c_r;

endmodule

### design/pcp_mac.sv
// shared multiply datapath: operand select, registered q15 product, writeback
// depends on pcp_pkg for the control word and q15 constants
`timescale 1ns / 1ps

module pcp_mac
  import pcp_pkg::*;
#(
  parameter int ADC_BITS = 12,
  localparam int AW = ADC_BITS + 4,
  localparam int YW = AW + 1,
  localparam int RW = YW + 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ucode_t                   ctl,
  input  logic                     load,
  input  logic [ADC_BITS-1:0]      sample_a,
  input  logic [ADC_BITS-1:0]      sample_b,
  input  logic [ADC_BITS-1:0]      sample_c,
  input  logic [ADC_BITS-1:0]      offset_a,
  input  logic [ADC_BITS-1:0]      offset_b,
  input  logic [ADC_BITS-1:0]      offset_c,
  input  logic signed [TRIG_W-1:0] sin_value,
  input  logic signed [TRIG_W-1:0] cos_value,
  output logic signed [YW-1:0]     alpha,
  output logic signed [YW-1:0]     beta,
  output logic signed [RW-1:0]     direct,
  output logic signed [RW-1:0]     quadrature
);

  localparam int PW = TRIG_W + YW;

  logic signed [AW-1:0]     a_r, b_r, c_r, a_nxt, b_nxt, c_nxt;
  logic signed [ADC_BITS:0] diff_a, diff_b, diff_c;
  logic signed [TRIG_W-1:0] sin_r, cos_r, x_op;
  logic signed [YW-1:0]     y_op, tmp_r, alpha_r, beta_r;
  logic signed [YW-1:0]     tmp_nxt, alpha_nxt, beta_nxt;
  logic signed [RW-1:0]     d_r, q_r, d_nxt, q_nxt;
  logic signed [PW-1:0]     prod_r, prod_shr;
  logic signed [YW:0]       p;
  logic signed [RW-1:0]     base, res;
  dst_t                     wb_dst_r;
  wbop_t                    wb_op_r;

  always_comb begin
    diff_a = $signed({1'b0, sample_a}) - $signed({1'b0, offset_a});
    diff_b = $signed({1'b0, sample_b}) - $signed({1'b0, offset_b});
    diff_c = $signed({1'b0, sample_c}) - $signed({1'b0, offset_c});
    a_nxt = load ? $signed({diff_a, 3'b000}) : a_r;
    b_nxt = load ? $signed({diff_b, 3'b000}) : b_r;
    c_nxt = load ? $signed({diff_c, 3'b000}) : c_r;
  end

  always_comb begin
    unique case (ctl.xsel)
      X_HALF:       x_op = Q15_HALF;
      X_TWO_THIRDS: x_op = Q15_TWO_THIRDS;
      X_INV_SQRT3:  x_op = Q15_INV_SQRT3;
      X_SIN:        x_op = sin_r;
      X_COS:        x_op = cos_r;
      default:      x_op = '0;
    endcase
    unique case (ctl.ysel)
      Y_BPC:   y_op = YW'(b_r) + YW'(c_r);
      Y_BMC:   y_op = YW'(b_r) - YW'(c_r);
      Y_TMP:   y_op = tmp_r;
      Y_BETA:  y_op = beta_r;
      Y_ALPHA: y_op = alpha_r;
      default: y_op = '0;
    endcase
  end

  // floor rounding of the q15 product is an arithmetic shift
  always_comb begin
    prod_shr = prod_r >>> Q15_SHIFT;
    p = prod_shr[YW:0];
    unique case (wb_dst_r)
      DST_TMP: base = RW'(a_r);
      DST_D:   base = d_r;
      DST_Q:   base = q_r;
      default: base = '0;
    endcase
    case (wb_op_r)
      WB_ADD:  res = base + RW'(p);
      WB_SUB:  res = base - RW'(p);
      default: res = RW'(p);
    endcase
    tmp_nxt = tmp_r;
    alpha_nxt = alpha_r;
    beta_nxt = beta_r;
    d_nxt = d_r;
    q_nxt = q_r;
    unique case (wb_dst_r)
      DST_TMP:   tmp_nxt = res[YW-1:0];
      DST_ALPHA: alpha_nxt = res[YW-1:0];
      DST_BETA:  beta_nxt = res[YW-1:0];
      DST_D:     d_nxt = res;
      DST_Q:     q_nxt = res;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_dst_r <= DST_NONE;
      wb_op_r <= WB_SET;
    end else begin
      wb_dst_r <= ctl.dst;
      wb_op_r <= ctl.op;
    end
    prod_r <= PW'(x_op) * PW'(y_op);
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    if (load) begin
      sin_r <= sin_value;
      cos_r <= cos_value;
    end
    tmp_r <= tmp_nxt;
    alpha_r <= alpha_nxt;
    beta_r <= beta_nxt;
    d_r <= d_nxt;
    q_r <= q_nxt;
  end

  assign alpha = alpha_r;
  assign beta = beta_r;
  assign direct = d_r;
  assign quadrature = q_r;

endmodule

### design/phase_current_clarke_park_unit.sv
// top level of the phase current clarke/park unit: microcode sequencer and stream ports
// depends on pcp_pkg, pcp_calib, pcp_mac and phase_current_clarke_park_unit_defines.svh
`timescale 1ns / 1ps
`include "phase_current_clarke_park_unit_defines.svh"

// Takes one item per transaction on the in_ stream. A calibration item
// (in_tuser = 0) is absorbed in the wait step and gives no result; after
// 2^CAL_SAMPLES_LOG2 of them the phase offsets are updated to the mean of
// the samples. A conversion item (in_tuser = 1) runs a ten-step microcode
// program on one shared multiplier: seven q15 products, one writeback
// drain and one handoff step, so the block takes no new item until the
// handoff step is done, and that step waits while the out_ stream stalls.
// Inputs are taken only while the sequencer sits in its wait step.
// All products are floored and nothing saturates.
module phase_current_clarke_park_unit
  import pcp_pkg::*;
#(
  parameter int CAL_SAMPLES_LOG2 = CAL_SAMPLES_LOG2_DEF,
  parameter int ADC_BITS = ADC_BITS_DEF,
  localparam int IN_DATA_W = ((3 * ADC_BITS + 2 * TRIG_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sample_a, sample_b, sample_c, sin_value, cos_value, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic [0:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // i_alpha, i_beta, i_direct, i_quadrature
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = ADC_BITS + 4;
  localparam int YW = AW + 1;
  localparam int RW = YW + 2;

  logic [STEP_W-1:0]     step_r, step_nxt;
  ucode_t                uw;
  logic                  in_xfer, conv_xfer, cal_xfer, out_free, emit;
  logic [ADC_BITS-1:0]   s_a, s_b, s_c, off_a, off_b, off_c;
  logic signed [TRIG_W-1:0] s_sin, s_cos;
  logic signed [YW-1:0]  alpha, beta;
  logic signed [RW-1:0]  direct, quadrature;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  assign s_a   = in_tdata[ADC_BITS-1:0];
  assign s_b   = in_tdata[2*ADC_BITS-1:ADC_BITS];
  assign s_c   = in_tdata[3*ADC_BITS-1:2*ADC_BITS];
  assign s_sin = in_tdata[3*ADC_BITS+TRIG_W-1:3*ADC_BITS];
  assign s_cos = in_tdata[3*ADC_BITS+2*TRIG_W-1:3*ADC_BITS+TRIG_W];

  assign uw        = ucode_rom(step_r);
  assign in_tready = (uw.jmp == J_WAIT_IN);
  assign in_xfer   = in_tvalid && in_tready;
  assign conv_xfer = in_xfer && in_tuser[0];
  assign cal_xfer  = in_xfer && !in_tuser[0];
  assign out_free  = !out_tvalid_r || out_tready;
  assign emit      = (uw.jmp == J_WAIT_OUT) && out_free;

  pcp_calib #(
    .ADC_BITS(ADC_BITS),
    .CAL_SAMPLES_LOG2(CAL_SAMPLES_LOG2)
  ) u_calib (
    .clk(clk),
    .rst_n(rst_n),
    .cal_en(cal_xfer),
    .sample_a(s_a),
    .sample_b(s_b),
    .sample_c(s_c),
    .offset_a(off_a),
    .offset_b(off_b),
    .offset_c(off_c)
  );

  pcp_mac #(
    .ADC_BITS(ADC_BITS)
  ) u_mac (
    .clk(clk),
    .rst_n(rst_n),
    .ctl(uw),
    .load(conv_xfer),
    .sample_a(s_a),
    .sample_b(s_b),
    .sample_c(s_c),
    .offset_a(off_a),
    .offset_b(off_b),
    .offset_c(off_c),
    .sin_value(s_sin),
    .cos_value(s_cos),
    .alpha(alpha),
    .beta(beta),
    .direct(direct),
    .quadrature(quadrature)
  );

  always_comb begin
    step_nxt = step_r;
    unique case (uw.jmp)
      J_NEXT:     step_nxt = step_r + 1'b1;
      J_WAIT_IN:  step_nxt = conv_xfer ? step_r + 1'b1 : step_r;
      J_WAIT_OUT: step_nxt = out_free ? '0 : step_r;
      J_HOME:     step_nxt = '0;
      default:    step_nxt = '0;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt = out_tdata_r;
    if (emit) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt = {I_QUAD_W'(quadrature), I_DIRECT_W'(direct),
                       I_BETA_W'(beta), I_ALPHA_W'(alpha)};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;

  `PCP_ASSERT_NEXT(a_conv_starts, conv_xfer, step_r == STEP_W'(1), "conversion did not start program")
  `PCP_ASSERT_NEXT(a_emit_valid, emit, out_tvalid, "handoff did not raise out_tvalid")
  `PCP_ASSERT_SAME(a_ready_idle, in_tready, step_r == '0 && !emit, "input taken outside wait step")
  `PCP_ASSERT_NEXT(a_cal_stays, cal_xfer, step_r == '0, "calibration item left the wait step")

endmodule
